FILE: rtl/core/trd_pkg.sv
// Shared types and constants for the TGA RLE pixel decoder.
package trd_pkg;

    localparam int unsigned CNT_W      = 25;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 25;
    localparam logic [CNT_W-1:0] MAX_PIXELS = 25'd16777216;
    localparam logic [2:0] BPP_FOUR = 3'd4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BYTES_PER_PIXEL = 1'b0,
        CFG_PIXEL_COUNT     = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic [7:0] alpha;
        logic [7:0] repeat_res;
        logic       image_done;
        logic       overrun;
    } t_pixel;

    typedef struct packed {
        logic space;
        logic push;
    } t_queue_ctl;

endpackage

FILE: rtl/core/trd_if.sv
// Channel interfaces: compressed byte requests in and decoded pixel requests out.
interface trd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface trd_pixel_if;
    logic       valid;
    logic       ready;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] alpha;
    logic [7:0] repeat_res;
    logic       image_done;
    logic       overrun;

    modport source (output valid, output blue, output green, output red, output alpha,
                    output repeat_res, output image_done, output overrun, input ready);
    modport sink   (input valid, input blue, input green, input red, input alpha,
                    input repeat_res, input image_done, input overrun, output ready);
endinterface

FILE: rtl/core/trd_front.sv
// Byte parser: packet headers, pixel assembly, run clipping and image accounting.
module trd_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [7:0]                    i_data,
    output logic                          o_ready,
    input  logic                          i_cfg_we,
    input  logic [trd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [trd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                          i_space,
    output trd_pkg::t_queue_ctl           o_ctl,
    output trd_pkg::t_pixel               o_pix
);

    logic                      r_four;
    logic [trd_pkg::CNT_W-1:0] r_cnt;
    logic                      r_in_packet, n_in_packet;
    logic                      r_is_run, n_is_run;
    logic [7:0]                r_left, n_left;
    logic [1:0]                r_bip, n_bip;
    logic [31:0]               r_colour, n_colour;
    logic [trd_pkg::CNT_W-1:0] r_done, n_done;

    logic                      accept;
    logic                      last_byte;
    logic                      emit;
    logic [7:0]                rep_raw;
    logic [7:0]                left_after;
    logic [trd_pkg::CNT_W:0]   rem;
    logic [trd_pkg::CNT_W:0]   rem_eff;
    logic                      img_done;
    logic                      clip;
    logic [7:0]                rep_out;
    logic [trd_pkg::CNT_W-1:0] cfg_cnt;

    assign o_ready = i_space;
    assign accept  = i_valid && i_space;

    always_comb begin
        cfg_cnt = i_cfg_data[trd_pkg::CNT_W-1:0];
        if (cfg_cnt == '0) begin
            cfg_cnt = trd_pkg::CNT_W'(1);
        end else if (cfg_cnt > trd_pkg::MAX_PIXELS) begin
            cfg_cnt = trd_pkg::MAX_PIXELS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_four <= 1'b0;
            r_cnt  <= trd_pkg::CNT_W'(1);
        end else if (i_cfg_we) begin
            case (trd_pkg::t_cfg_idx'(i_cfg_idx))
                trd_pkg::CFG_BYTES_PER_PIXEL: r_four <= (i_cfg_data[2:0] == trd_pkg::BPP_FOUR);
                trd_pkg::CFG_PIXEL_COUNT:     r_cnt  <= cfg_cnt;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_in_packet = r_in_packet;
        n_is_run    = r_is_run;
        n_left      = r_left;
        n_bip       = r_bip;
        n_colour    = r_colour;
        n_done      = r_done;
        emit        = 1'b0;

        last_byte  = r_four ? (r_bip == 2'd3) : (r_bip >= 2'd2);
        rep_raw    = (r_is_run && r_left != 8'd0) ? r_left : 8'd1;
        left_after = r_is_run ? 8'd0 : ((r_left != 8'd0) ? r_left - 8'd1 : 8'd0);
        rem        = {1'b0, r_cnt} - {1'b0, r_done};
        rem_eff    = (rem[trd_pkg::CNT_W] || rem == '0) ? (trd_pkg::CNT_W+1)'(1) : rem;
        img_done   = {{(trd_pkg::CNT_W-7){1'b0}}, rep_raw} >= rem_eff;
        clip       = {{(trd_pkg::CNT_W-7){1'b0}}, rep_raw} > rem_eff;
        rep_out    = clip ? rem_eff[7:0] : rep_raw;

        case (r_bip)
            2'd0:    n_colour[7:0]   = i_data;
            2'd1:    n_colour[15:8]  = i_data;
            2'd2:    n_colour[23:16] = i_data;
            default: n_colour[31:24] = i_data;
        endcase

        if (accept) begin
            if (!r_in_packet) begin
                n_is_run    = i_data[7];
                n_left      = i_data[7] ? i_data - 8'd127 : i_data + 8'd1;
                n_bip       = 2'd0;
                n_in_packet = 1'b1;
                n_colour    = r_colour;
            end else if (!last_byte) begin
                n_bip = r_bip + 2'd1;
            end else begin
                emit   = 1'b1;
                n_bip  = 2'd0;
                n_left = left_after;
                if (img_done) begin
                    n_done = '0;
                    n_left = 8'd0;
                end else begin
                    n_done = r_done + {{(trd_pkg::CNT_W-8){1'b0}}, rep_raw};
                end
                if (img_done || left_after == 8'd0) begin
                    n_in_packet = 1'b0;
                    n_is_run    = 1'b0;
                end
            end
        end else begin
            n_colour = r_colour;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_packet <= 1'b0;
            r_is_run    <= 1'b0;
            r_left      <= 8'd0;
            r_bip       <= 2'd0;
            r_colour    <= 32'd0;
            r_done      <= '0;
        end else begin
            r_in_packet <= n_in_packet;
            r_is_run    <= n_is_run;
            r_left      <= n_left;
            r_bip       <= n_bip;
            r_colour    <= n_colour;
            r_done      <= n_done;
        end
    end

    assign o_ctl.space       = i_space;
    assign o_ctl.push        = emit;
    assign o_pix.blue        = n_colour[7:0];
    assign o_pix.green       = n_colour[15:8];
    assign o_pix.red         = n_colour[23:16];
    assign o_pix.alpha       = r_four ? n_colour[31:24] : 8'd0;
    assign o_pix.repeat_res  = rep_out;
    assign o_pix.image_done  = img_done;
    assign o_pix.overrun     = clip || (img_done && left_after != 8'd0);

endmodule

FILE: rtl/core/trd_queue.sv
// Two-entry queue that holds decoded pixels until the output side takes them.
module trd_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  trd_pkg::t_queue_ctl i_ctl,
    input  trd_pkg::t_pixel     i_pix,
    output logic                o_space,
    output logic                o_valid,
    input  logic                i_ready,
    output trd_pkg::t_pixel     o_pix
);

    trd_pkg::t_pixel r_mem [2];
    logic            r_wptr;
    logic            r_rptr;
    logic [1:0]      r_count;
    logic            push;
    logic            pop;

    assign o_space = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign push    = i_ctl.push && i_ctl.space;
    assign pop     = o_valid && i_ready;
    assign o_pix   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= i_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (push) begin
                r_wptr <= ~r_wptr;
            end
            if (pop) begin
                r_rptr <= ~r_rptr;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: rtl/core/tga_rle_pixel_decoder.sv
// A pixel result is written into the pixel queue and offered to the output from there.
// Throughput: one byte request per cycle while the pixel queue has space.
// A two-entry pixel queue lets input continue while a result waits to be taken.
// Header bytes and non-final pixel bytes give no result.
// Reset is synchronous and active low: parser state clears, bytes_per_pixel is 3,
// pixel_count is 1.
module tga_rle_pixel_decoder (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    trd_byte_if.sink                       i_byte,
    trd_pixel_if.source                    o_pixel,
    input  logic                           i_cfg_we,
    input  logic [trd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [trd_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    trd_pkg::t_queue_ctl ctl;
    trd_pkg::t_pixel     front_pix;
    trd_pkg::t_pixel     out_pix;
    logic                space;

    trd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_byte.valid),
        .i_data     (i_byte.data_byte),
        .o_ready    (i_byte.ready),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_space    (space),
        .o_ctl      (ctl),
        .o_pix      (front_pix)
    );

    trd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_pix   (front_pix),
        .o_space (space),
        .o_valid (o_pixel.valid),
        .i_ready (o_pixel.ready),
        .o_pix   (out_pix)
    );

    assign o_pixel.blue       = out_pix.blue;
    assign o_pixel.green      = out_pix.green;
    assign o_pixel.red        = out_pix.red;
    assign o_pixel.alpha      = out_pix.alpha;
    assign o_pixel.repeat_res = out_pix.repeat_res;
    assign o_pixel.image_done = out_pix.image_done;
    assign o_pixel.overrun    = out_pix.overrun;

endmodule
